FILE: hw/rtl/lpsd_pkg.sv
// Shared types and constants for the length-prefixed stream deframer.
// Used by length_prefix_stream_deframer; depends on nothing.

package lpsd_pkg;

  // Field widths fixed by the stream format and result layout
  localparam int unsigned LenW      = 24;  // packet length field
  localparam int unsigned AccW      = 32;  // header accumulator (4 bytes)
  localparam int unsigned CountW    = 5;   // queued packet count
  localparam int unsigned TotalW    = 32;  // queued byte total
  localparam int unsigned HdrCntW   = 3;   // header byte counter
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam logic [HdrCntW-1:0] LengthBytes = 3'd4;

  // Defaults
  localparam int unsigned DefQueueDepth = 16;
  localparam logic [LenW-1:0]   RstMaxPacketBytes = 24'd1048576;
  localparam logic [CountW-1:0] RstMaxQueuedCount = 5'd16;
  localparam logic [TotalW-1:0] RstMaxQueuedBytes = 32'd16777216;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_LENGTH = 2'd1,
    STAT_QUEUE_FULL = 2'd2,
    STAT_INVALID    = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_PACKET_BYTES = 2'd0,
    CFG_MAX_QUEUED_COUNT = 2'd1,
    CFG_MAX_QUEUED_BYTES = 2'd2
  } cfg_idx_e;

  // One result item
  typedef struct packed {
    logic              payload_valid;
    logic [7:0]        payload_byte;
    logic              last_of_packet;
    status_e           status;
    logic              popped;
    logic [LenW-1:0]   popped_length;
    logic [CountW-1:0] queue_count;
  } result_t;

endpackage

FILE: hw/rtl/lpsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.

module lpsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/length_prefix_stream_deframer.sv
// Top level of the length-prefixed stream deframer.
// Depends on lpsd_pkg and lpsd_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event per transfer:
//   a stream byte, a pop of the oldest queued packet, or a clear. Each
//   packet on the stream is a 4-byte little-endian length followed by that
//   many payload bytes. Every input transfer yields exactly one result
//   transfer on the output channel (out_valid_o / out_stall_i) carrying the
//   passed payload byte, last marker, status, pop result and queue count.
//   Throughput: one item per cycle; all per-item work is a single pass of
//   compare/add logic between the state registers and the result register.
//   The queued lengths live in a RAM whose registered read port always
//   looks at the next head entry, with a one-entry bypass for a write to it.
//   Stall: a result register plus one skid entry; the input stalls only
//   when both are full, so one item is still taken while a result waits.
//   Reset: asynchronous, active low; clears all framing state and queue
//   pointers and loads register defaults. No clearing pass is needed.
//   Configuration: cfg_we_i writes register cfg_index_i (0 max packet bytes,
//   1 max queued count, 2 max queued bytes); the user must write only
//   while the block is idle, and the block itself does not enforce this.

module length_prefix_stream_deframer #(
  parameter int unsigned QUEUE_DEPTH = lpsd_pkg::DefQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic [lpsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lpsd_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [7:0]                    data_byte_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          payload_valid_o,
  output logic [7:0]                    payload_byte_o,
  output logic                          last_of_packet_o,
  output logic [1:0]                    status_o,
  output logic                          popped_o,
  output logic [lpsd_pkg::LenW-1:0]     popped_length_o,
  output logic [lpsd_pkg::CountW-1:0]   queue_count_o
);

  localparam int unsigned PtrW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned DepthCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CmpW    = (DepthCW > lpsd_pkg::CountW) ? DepthCW : lpsd_pkg::CountW;
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CmpW-1:0] DepthCmp = CmpW'(QUEUE_DEPTH);

  // Configuration registers
  logic [lpsd_pkg::LenW-1:0]   max_packet_q;
  logic [lpsd_pkg::CountW-1:0] max_count_q;
  logic [lpsd_pkg::TotalW-1:0] max_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_packet_q <= lpsd_pkg::RstMaxPacketBytes;
      max_count_q  <= lpsd_pkg::RstMaxQueuedCount;
      max_bytes_q  <= lpsd_pkg::RstMaxQueuedBytes;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lpsd_pkg::CFG_MAX_PACKET_BYTES: max_packet_q <= cfg_wdata_i[lpsd_pkg::LenW-1:0];
        lpsd_pkg::CFG_MAX_QUEUED_COUNT: max_count_q  <= cfg_wdata_i[lpsd_pkg::CountW-1:0];
        lpsd_pkg::CFG_MAX_QUEUED_BYTES: max_bytes_q  <= cfg_wdata_i[lpsd_pkg::TotalW-1:0];
        default: ;
      endcase
    end
  end

  // Framing and queue state
  logic [lpsd_pkg::HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [lpsd_pkg::AccW-1:0]    len_acc_q, len_acc_d;
  logic [lpsd_pkg::LenW-1:0]    remain_q, remain_d;
  logic                         invalid_q, invalid_d;
  logic [lpsd_pkg::CountW-1:0]  queued_q, queued_d;
  logic [lpsd_pkg::TotalW-1:0]  total_q, total_d;
  logic [PtrW-1:0]              head_q, head_d;
  logic [PtrW-1:0]              tail_q, tail_d;

  // Head entry read path with bypass for a write to the next head
  logic                      byp_q, byp_d;
  logic [lpsd_pkg::LenW-1:0] byp_data_q;
  logic [lpsd_pkg::LenW-1:0] ram_rdata;
  logic [lpsd_pkg::LenW-1:0] head_len;
  logic                      push;
  logic [lpsd_pkg::LenW-1:0] push_len;

  // Handshake and result buffering
  logic              accept_in;
  logic              out_take;
  lpsd_pkg::result_t res_d;
  lpsd_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign accept_in  = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;

  assign head_len = byp_q ? byp_data_q : ram_rdata;

  // Per-item processing
  always_comb begin
    logic [lpsd_pkg::AccW-1:0]   acc_new;
    logic [lpsd_pkg::LenW-1:0]   rem_dec;
    logic [lpsd_pkg::TotalW:0]   total_sum;
    logic                        count_full;
    logic                        bytes_full;

    acc_new    = len_acc_q | (lpsd_pkg::AccW'(data_byte_i) << {hdr_cnt_q[1:0], 3'b000});
    rem_dec    = (remain_q != '0) ? remain_q - 1'b1 : remain_q;
    total_sum  = {1'b0, total_q} + (lpsd_pkg::TotalW + 1)'(len_acc_q[lpsd_pkg::LenW-1:0]);
    count_full = (queued_q >= max_count_q) || (CmpW'(queued_q) >= DepthCmp);
    bytes_full = total_sum > {1'b0, max_bytes_q};

    hdr_cnt_d = hdr_cnt_q;
    len_acc_d = len_acc_q;
    remain_d  = remain_q;
    invalid_d = invalid_q;
    queued_d  = queued_q;
    total_d   = total_q;
    head_d    = head_q;
    tail_d    = tail_q;
    push      = 1'b0;
    push_len  = len_acc_q[lpsd_pkg::LenW-1:0];

    res_d                = '0;
    res_d.status         = lpsd_pkg::STAT_OK;
    res_d.queue_count    = queued_q;

    if (accept_in) begin
      case (kind_i)
        lpsd_pkg::KIND_BYTE: begin
          if (invalid_q) begin
            // Drop bytes until a clear
            res_d.status = lpsd_pkg::STAT_INVALID;
          end else if (hdr_cnt_q < lpsd_pkg::LengthBytes) begin
            // Collect the length prefix, check it on its last byte
            len_acc_d = acc_new;
            hdr_cnt_d = hdr_cnt_q + 1'b1;
            if (hdr_cnt_q == lpsd_pkg::LengthBytes - 1'b1) begin
              if (acc_new == '0 || acc_new > lpsd_pkg::AccW'(max_packet_q)) begin
                invalid_d    = 1'b1;
                res_d.status = lpsd_pkg::STAT_BAD_LENGTH;
                hdr_cnt_d    = '0;
                len_acc_d    = '0;
              end else begin
                remain_d = acc_new[lpsd_pkg::LenW-1:0];
              end
            end
          end else begin
            // Pass the payload byte, queue the packet on its last byte if it fits
            res_d.payload_valid = 1'b1;
            res_d.payload_byte  = data_byte_i;
            remain_d            = rem_dec;
            if (rem_dec == '0) begin
              res_d.last_of_packet = 1'b1;
              if (count_full || bytes_full) begin
                invalid_d    = 1'b1;
                res_d.status = lpsd_pkg::STAT_QUEUE_FULL;
              end else begin
                push     = 1'b1;
                tail_d   = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
                queued_d = queued_q + 1'b1;
                total_d  = total_sum[lpsd_pkg::TotalW-1:0];
              end
              hdr_cnt_d = '0;
              len_acc_d = '0;
            end
          end
          res_d.queue_count = queued_d;
        end
        lpsd_pkg::KIND_POP: begin
          // Release the oldest queued length
          if (queued_q != '0) begin
            res_d.popped        = 1'b1;
            res_d.popped_length = head_len;
            head_d   = (head_q == LastPtr) ? '0 : head_q + 1'b1;
            queued_d = queued_q - 1'b1;
            total_d  = (total_q >= lpsd_pkg::TotalW'(head_len)) ?
                       total_q - lpsd_pkg::TotalW'(head_len) : '0;
          end
          res_d.queue_count = queued_d;
        end
        lpsd_pkg::KIND_CLEAR: begin
          // Reset all framing and queue state
          hdr_cnt_d = '0;
          len_acc_d = '0;
          remain_d  = '0;
          invalid_d = 1'b0;
          queued_d  = '0;
          total_d   = '0;
          head_d    = '0;
          tail_d    = '0;
          res_d.queue_count = '0;
        end
        default: ;
      endcase
    end

    byp_d = push && (tail_q == head_d);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      len_acc_q <= '0;
      remain_q  <= '0;
      invalid_q <= 1'b0;
      queued_q  <= '0;
      total_q   <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      byp_q     <= 1'b0;
    end else begin
      hdr_cnt_q <= hdr_cnt_d;
      len_acc_q <= len_acc_d;
      remain_q  <= remain_d;
      invalid_q <= invalid_d;
      queued_q  <= queued_d;
      total_q   <= total_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      byp_q     <= byp_d;
    end
  end

  // Hold the bypass data
  always_ff @(posedge clk_i) begin
    byp_data_q <= push_len;
  end

  // Length queue storage
  lpsd_ram #(
    .Width(lpsd_pkg::LenW),
    .Depth(QUEUE_DEPTH)
  ) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (push),
    .waddr_i(tail_q),
    .wdata_i(push_len),
    .raddr_i(head_d),
    .rdata_o(ram_rdata)
  );

  // Result register and skid entry control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept_in;
      end
    end else if (accept_in) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result and skid payload
  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept_in) begin
        out_q <= res_d;
      end
    end else if (accept_in) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_valid_o  = out_q.payload_valid;
  assign payload_byte_o   = out_q.payload_byte;
  assign last_of_packet_o = out_q.last_of_packet;
  assign status_o         = out_q.status;
  assign popped_o         = out_q.popped;
  assign popped_length_o  = out_q.popped_length;
  assign queue_count_o    = out_q.queue_count;

endmodule
